### design/lzw_encoder_unit_macros.svh
// ---------------------------------------------------------------------------
// lzw encoder assertion macros
// shared concurrent assertion wrappers, clocked on clk_i; LZWE_ASSERT is disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef LZW_ENCODER_UNIT_MACROS_SVH
`define LZW_ENCODER_UNIT_MACROS_SVH

// property checked while out of reset
`define LZWE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked during reset too
`define LZWE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### design/lzwe_pkg.sv
// ---------------------------------------------------------------------------
// lzw encoder package
// beat payload types and controller/datapath command and status groups
// ---------------------------------------------------------------------------
package lzwe_pkg;

  localparam int unsigned SymW  = 8;
  localparam int unsigned CodeW = 12;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            end_of_stream;
  } in_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             last_code;
  } out_t;

  typedef struct packed {
    logic clr_step;
    logic load_in;
    logic set_prefix_sym;
    logic probe_start;
    logic probe_next;
    logic hit_take;
    logic miss_emit;
    logic flush_emit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic prefix_valid;
    logic eos;
    logic rd_hit;
    logic rd_empty;
    logic out_free;
  } status_t;

endpackage

### design/lzw_encoder_unit.sv
// ---------------------------------------------------------------------------
// lzw encoder unit
// 12-bit lzw compressor, one byte beat in, dictionary codes out
// ---------------------------------------------------------------------------
// input channel: one symbol byte per beat, end_of_stream marks the last byte
// output channel: code beats, last_code set on the flushed final code
// each input beat gives zero, one (miss or flush) or two (miss then flush)
// output beats; the dictionary is kept from one stream to the next
// the (prefix, symbol) pairs live in a hash table of 2**clog2(DICT_SIZE)
// words with linear probing; each probe passes a read and a compare state
// a beat with a prefix is probed until a hit or an empty word (a miss);
// a miss emits the prefix code and a flush then emits the final code
// a code appears on the output register the cycle after it is formed
// reset runs a clearing pass over all 2**clog2(DICT_SIZE) table words
// (4096 by default) before the first beat is accepted
// a stalled receiver holds the output register; the block waits to emit
// until the register frees and takes no new beat meanwhile
// ---------------------------------------------------------------------------
module lzw_encoder_unit #(
  parameter int unsigned DICT_SIZE = 4096,
  parameter int unsigned ALPHABET  = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lzwe_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lzwe_pkg::out_t out_data_o
);
  import lzwe_pkg::*;

  // command and status between the sequencer and the table datapath
  cmd_t    cmd;
  status_t status;

  lzwe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lzwe_dp #(
    .DICT_SIZE (DICT_SIZE),
    .ALPHABET  (ALPHABET)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

### design/lzwe_ctrl.sv
// ---------------------------------------------------------------------------
// lzw encoder controller
// sequences table clear, hashed probe, miss emit and flush
// ---------------------------------------------------------------------------
`include "lzw_encoder_unit_macros.svh"

module lzwe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lzwe_pkg::status_t status_i,
  output lzwe_pkg::cmd_t    cmd_o
);
  import lzwe_pkg::*;

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SStart = 3'd2;
  localparam logic [2:0] SRead  = 3'd3;
  localparam logic [2:0] SCmp   = 3'd4;
  localparam logic [2:0] SMiss  = 3'd5;
  localparam logic [2:0] SFlush = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      SClear: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_done) state_d = SIdle;
      end
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = SStart;
        end
      end
      SStart: begin
        if (!status_i.prefix_valid) begin
          cmd_o.set_prefix_sym = 1'b1;
          state_d = status_i.eos ? SFlush : SIdle;
        end else begin
          cmd_o.probe_start = 1'b1;
          state_d = SRead;
        end
      end
      SRead: state_d = SCmp;
      SCmp: begin
        if (status_i.rd_hit) begin
          cmd_o.hit_take = 1'b1;
          state_d = status_i.eos ? SFlush : SIdle;
        end else if (status_i.rd_empty) begin
          state_d = SMiss;
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d = SRead;
        end
      end
      SMiss: begin
        if (status_i.out_free) begin
          cmd_o.miss_emit = 1'b1;
          state_d = status_i.eos ? SFlush : SIdle;
        end
      end
      SFlush: begin
        if (status_i.out_free) begin
          cmd_o.flush_emit = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SClear;
    else         state_q <= state_d;
  end

  `LZWE_ASSERT(a_no_accept_clear, (state_q == SClear) |-> !in_ready_o, "accept during clear")
  `LZWE_ASSERT(a_emit_free, (cmd_o.miss_emit || cmd_o.flush_emit) |-> status_i.out_free, "emit without free slot")
  `LZWE_ASSERT(a_accept_start, (in_valid_i && in_ready_o) |=> (state_q == SStart), "accept did not start item")

endmodule

### design/lzwe_dp.sv
// ---------------------------------------------------------------------------
// lzw encoder datapath
// hashed pair table, prefix and free code registers, output register
// ---------------------------------------------------------------------------
module lzwe_dp #(
  parameter int unsigned DICT_SIZE = 4096,
  parameter int unsigned ALPHABET  = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lzwe_pkg::in_t     in_data_i,
  input  lzwe_pkg::cmd_t    cmd_i,
  output lzwe_pkg::status_t status_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output lzwe_pkg::out_t    out_data_o
);
  import lzwe_pkg::*;

  localparam int unsigned CW  = $clog2(DICT_SIZE);
  localparam int unsigned TBL = 2 ** CW;
  localparam int unsigned EW  = 1 + CW + SymW + CW;

  logic [EW-1:0] mem_q [TBL];
  logic [EW-1:0] rd_q;
  logic [CW-1:0] addr_q, clr_cnt_q;
  logic [CW-1:0] prefix_q;
  logic          pvalid_q;
  logic [CW:0]   nfc_q;
  logic [SymW-1:0] sym_q, sym_sat;
  logic          eos_q;
  logic          out_valid_q;
  out_t          out_q;
  logic          room, wr_en;
  logic [CW-1:0] wr_addr, hash;
  logic [EW-1:0] wr_data;

  // fields of a table word: valid, prefix, symbol, code
  logic          rd_valid;
  logic [CW-1:0] rd_prefix, rd_code;
  logic [SymW-1:0] rd_sym;
  assign rd_valid  = rd_q[EW-1];
  assign rd_prefix = rd_q[EW-2 -: CW];
  assign rd_sym    = rd_q[CW+SymW-1 -: SymW];
  assign rd_code   = rd_q[CW-1:0];

  assign sym_sat = ({1'b0, in_data_i.symbol} >= (SymW+1)'(ALPHABET)) ?
                   SymW'(ALPHABET - 1) : in_data_i.symbol;
  assign hash    = prefix_q ^ (CW'(sym_q) << (CW - SymW));
  assign room    = nfc_q < (CW+1)'(DICT_SIZE);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = {1'b1, prefix_q, sym_q, nfc_q[CW-1:0]};
    if (cmd_i.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
      wr_data = '0;
    end else if (cmd_i.miss_emit && room) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sym_q <= sym_sat;
      eos_q <= in_data_i.end_of_stream;
    end
    if (cmd_i.probe_start)     addr_q <= hash;
    else if (cmd_i.probe_next) addr_q <= addr_q + 1'b1;
    if (cmd_i.miss_emit) out_q <= '{code: CodeW'(prefix_q), last_code: 1'b0};
    else if (cmd_i.flush_emit) out_q <= '{code: CodeW'(prefix_q), last_code: 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      prefix_q    <= '0;
      pvalid_q    <= 1'b0;
      nfc_q       <= (CW+1)'(ALPHABET);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.set_prefix_sym) begin
        prefix_q <= CW'(sym_q);
        pvalid_q <= 1'b1;
      end else if (cmd_i.hit_take) begin
        prefix_q <= rd_code;
      end else if (cmd_i.miss_emit) begin
        prefix_q <= CW'(sym_q);
      end else if (cmd_i.flush_emit) begin
        prefix_q <= '0;
        pvalid_q <= 1'b0;
      end
      if (cmd_i.miss_emit && room) nfc_q <= nfc_q + 1'b1;
      if (cmd_i.miss_emit || cmd_i.flush_emit) out_valid_q <= 1'b1;
      else if (out_ready_i)                    out_valid_q <= 1'b0;
    end
  end

  assign status_o.clr_done     = &clr_cnt_q;
  assign status_o.prefix_valid = pvalid_q;
  assign status_o.eos          = eos_q;
  assign status_o.rd_hit       = rd_valid && rd_prefix == prefix_q && rd_sym == sym_q;
  assign status_o.rd_empty     = !rd_valid;
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sim/tb_lzw_encoder_unit.sv
// ---------------------------------------------------------------------------
// lzw encoder unit testbench
// drives byte streams through the encoder with random gaps on both sides,
// predicts every code with a behavioral dictionary and checks each beat
// ---------------------------------------------------------------------------
module tb_lzw_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lzwe_pkg::*;

  localparam int unsigned DictSize = 4096;
  localparam int unsigned Alphabet = 256;
  localparam int unsigned IdleLimit = 200000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  lzw_encoder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // predictor state: learned pairs, next code and the prefix being grown
  logic [19:0] dict_pairs[DictSize];
  int unsigned dict_next;
  logic [11:0] cur_prefix;
  logic        have_prefix;

  out_t code_queue[$];
  int   fail_count;
  int   beats_sent;
  int   codes_seen;
  int   idle_cycles;
  bit   hold_off;    // long receiver stall requested by the backpressure test

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // search learned pairs for (prefix, symbol); returns DictSize on a miss
  function automatic int unsigned lookup_pair(logic [11:0] p, logic [7:0] s);
    int unsigned i;
    lookup_pair = DictSize;
    for (i = Alphabet; i < dict_next; i++) begin
      if (dict_pairs[i[11:0]] == {p, s}) begin
        lookup_pair = i;
        break;
      end
    end
  endfunction

  // advance the dictionary by one symbol and queue the codes it yields
  task automatic predict_codes(in_t beat);
    logic [7:0]  s;
    int unsigned hit;
    out_t        c;
    s = beat.symbol;
    if (!have_prefix) begin
      cur_prefix  = 12'(s);
      have_prefix = 1'b1;
    end else begin
      hit = lookup_pair(cur_prefix, s);
      if (hit < DictSize) begin
        cur_prefix = hit[11:0];
      end else begin
        c.code = cur_prefix;
        c.last_code = 1'b0;
        code_queue = {code_queue, c};
        if (dict_next < DictSize) begin
          dict_pairs[dict_next[11:0]] = {cur_prefix, s};
          dict_next++;
        end
        cur_prefix = 12'(s);
      end
    end
    if (beat.end_of_stream) begin
      c.code = cur_prefix;
      c.last_code = 1'b1;
      code_queue = {code_queue, c};
      have_prefix = 1'b0;
      cur_prefix  = '0;
    end
  endtask

  // mostly short gaps, now and then a long one, often none
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) pick_gap = 0;
    else if (r < 94) pick_gap = $urandom_range(1, 3);
    else pick_gap = $urandom_range(10, 40);
  endfunction

  // offer one beat at the falling edge and hold it until taken
  task automatic send_symbol(logic [7:0] sym, logic eos);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk_i);
    in_data_i.symbol        = sym;
    in_data_i.end_of_stream = eos;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_codes(in_data_i);
    beats_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // receiver readiness, changed at falling edges only
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) out_ready_i = 1'b0;
      else out_ready_i = (pick_gap() == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  // code beat checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      codes_seen++;
      if (code_queue.size() == 0) begin
        $error("unexpected code beat %0d", out_data_o.code);
        fail_count++;
      end else begin
        if (out_data_o.code !== code_queue[0].code) begin
          $error("code: expected %0d got %0d", code_queue[0].code, out_data_o.code);
          fail_count++;
        end
        if (out_data_o.last_code !== code_queue[0].last_code) begin
          $error("last_code: expected %0b got %0b",
                 code_queue[0].last_code, out_data_o.last_code);
          fail_count++;
        end
        void'(code_queue.pop_front());
      end
    end
  end

  // watchdog on cycles with no beat moving either way; counts from reset,
  // so the clearing pass falls well inside the limit
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // extremes of the symbol, single-byte streams and repeated runs
  task automatic test_directed();
    send_symbol(8'h00, 1'b1);
    send_symbol(8'hff, 1'b1);
    send_symbol(8'h41, 1'b0);
    send_symbol(8'h41, 1'b0);
    send_symbol(8'h41, 1'b0);
    send_symbol(8'h41, 1'b0);
    send_symbol(8'h41, 1'b1);
    send_symbol(8'h41, 1'b0);
    send_symbol(8'h41, 1'b0);
    send_symbol(8'h41, 1'b1);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hff, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hff, 1'b1);
    send_symbol(8'haa, 1'b0);
    send_symbol(8'h55, 1'b1);
  endtask

  // receiver stalls a long stretch while streams keep coming, so the
  // output register fills and the block backs up its input
  task automatic test_backpressure();
    int i;
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (i = 0; i < 20; i++) send_symbol(8'($urandom_range(0, 3)), i % 7 == 6);
    join
  endtask

  // random streams over small and full alphabets, some long enough to
  // grow long prefixes
  task automatic test_random_streams(int total);
    int n;
    int len;
    int span;
    int k;
    n = 0;
    while (n < total) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
      span = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(1, 7);
      for (k = 0; k < len && n < total; k++) begin
        send_symbol(8'($urandom_range(0, span)), (k == len - 1) || (n == total - 1));
        n++;
      end
    end
  endtask

  // one long full-alphabet stream, nearly every byte adds an entry
  task automatic test_dictionary_fill();
    int k;
    for (k = 0; k < 200; k++) send_symbol(8'($urandom_range(0, 255)), k == 199);
  endtask

  initial begin
    in_valid_i = 1'b0;
    in_data_i  = '0;
    hold_off   = 1'b0;
    fail_count = 0;
    beats_sent = 0;
    codes_seen = 0;
    idle_cycles = 0;
    dict_next  = Alphabet;
    cur_prefix = '0;
    have_prefix = 1'b0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_backpressure();
    test_random_streams(900);
    test_dictionary_fill();

    while (code_queue.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("covered %0d symbol beats and %0d code beats, dictionary at %0d codes",
             beats_sent, codes_seen, dict_next);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/lzwe_pkg.sv
design/lzwe_ctrl.sv
design/lzwe_dp.sv
design/lzw_encoder_unit.sv
sim/tb_lzw_encoder_unit.sv
